>>> sv/pel_pkg.sv
// pel_pkg: shared types, constants and hex decode for the percent-encoded list decoder
// depends on nothing; imported by percent_encoded_list_decoder
`timescale 1ns / 1ps

package pel_pkg;

  localparam int unsigned CountBits = 16;
  localparam int unsigned MaxRes    = 3;
  localparam int unsigned HexRadix  = 16;

  localparam logic [7:0]  ChAmp     = 8'h26;
  localparam logic [7:0]  ChPct     = 8'h25;
  localparam logic [15:0] ShownMax  = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_ELEM = 2'd1,
    KIND_DONE = 2'd2,
    KIND_BAD  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ESC_IDLE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_DIGIT = 2'd2
  } esc_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [15:0] total;
  } res_t;

  // valid flag in the top bit, nibble value below
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h41 + 8'd10)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h61 + 8'd10)};
    end
    return r;
  endfunction

endpackage

>>> sv/percent_encoded_list_decoder.sv
// a word's first result is registered, shown in the cycle after the word is accepted
// throughput: one input word per cycle while each word gives at most one result
// and m_axis_tready is high; the result buffer drains one entry a cycle while it is high;
// a word giving more results holds the input until the last, when the next word is taken
// reset: asynchronous active low, clears the decode state and tally, empties the buffer
// depends on pel_pkg
`timescale 1ns / 1ps

module percent_encoded_list_decoder
  import pel_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] char_in
  input  logic        s_axis_tlast,  // final_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [7:0] decoded_byte, [23:8] element_total
  output logic [1:0]  m_axis_tuser,  // [1:0] kind
  output logic        m_axis_tlast   // run_end
);

  logic                 expect_first_q, expect_first_d;
  logic                 bad_start_q, bad_start_d;
  esc_e                 esc_q, esc_d;
  logic [7:0]           held_q, held_d;
  logic [CountBits-1:0] tally_q, tally_d;

  res_t                 buf_q [MaxRes];
  res_t                 res_d [MaxRes];
  logic [1:0]           cnt_q, cnt_d;
  logic [1:0]           idx_q, idx_d;
  logic [1:0]           n_res;

  logic                 s_acc, m_take, last_take;
  logic [7:0]           c;
  logic                 fin;
  logic [4:0]           hv_c, hv_h;
  logic [CountBits-1:0] tally_inc;
  logic [15:0]          shown_old, shown_inc;

  assign c   = s_axis_tdata;
  assign fin = s_axis_tlast;

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_take        = m_axis_tvalid & m_axis_tready;
  assign last_take     = m_take & (idx_q == cnt_q - 2'd1);
  assign s_axis_tready = (cnt_q == 2'd0) | last_take;
  assign s_acc         = s_axis_tvalid & s_axis_tready;

  assign hv_c      = hex_val(c);
  assign hv_h      = hex_val(held_q);
  assign tally_inc = (tally_q == {CountBits{1'b1}}) ? tally_q : tally_q + 1'b1;
  assign shown_old = (32'(tally_q) > 32'(ShownMax)) ? ShownMax : 16'(tally_q);
  assign shown_inc = (32'(tally_inc) > 32'(ShownMax)) ? ShownMax : 16'(tally_inc);

  // decode of one word into state update and up to three results
  always_comb begin
    logic ord;
    expect_first_d = expect_first_q;
    bad_start_d    = bad_start_q;
    esc_d          = esc_q;
    held_d         = held_q;
    tally_d        = tally_q;
    n_res          = 2'd0;
    ord            = 1'b0;
    for (int i = 0; i < int'(MaxRes); i++) begin
      res_d[i] = '{kind: KIND_DATA, data: 8'd0, total: 16'd0};
    end

    if (expect_first_q) begin
      expect_first_d = 1'b0;
      bad_start_d    = (c != ChAmp);
      esc_d          = ESC_IDLE;
      held_d         = 8'd0;
      tally_d        = '0;
      if (fin) begin
        res_d[0] = '{kind: (c != ChAmp) ? KIND_BAD : KIND_DONE, data: 8'd0, total: 16'd0};
        n_res    = 2'd1;
      end
    end else if (bad_start_q) begin
      if (fin) begin
        res_d[0] = '{kind: KIND_BAD, data: 8'd0, total: shown_old};
        n_res    = 2'd1;
      end
    end else if (fin) begin
      if (c != ChAmp) begin
        res_d[0] = '{kind: KIND_BAD, data: 8'd0, total: shown_old};
        n_res    = 2'd1;
      end else if (esc_q == ESC_DIGIT) begin
        res_d[0] = '{kind: KIND_DATA, data: held_q, total: shown_old};
        res_d[1] = '{kind: KIND_ELEM, data: 8'd0, total: shown_inc};
        res_d[2] = '{kind: KIND_DONE, data: 8'd0, total: shown_inc};
        n_res    = 2'd3;
      end else begin
        res_d[0] = '{kind: KIND_ELEM, data: 8'd0, total: shown_inc};
        res_d[1] = '{kind: KIND_DONE, data: 8'd0, total: shown_inc};
        n_res    = 2'd2;
      end
    end else begin
      unique case (esc_q)
        ESC_PCT: begin
          if (hv_c[4]) begin
            held_d = c;
            esc_d  = ESC_DIGIT;
          end else begin
            esc_d = ESC_IDLE;
            ord   = 1'b1;
          end
        end
        ESC_DIGIT: begin
          esc_d  = ESC_IDLE;
          held_d = 8'd0;
          if (hv_c[4] && hv_h[4]) begin
            res_d[0] = '{kind: KIND_DATA, data: {hv_h[3:0], hv_c[3:0]}, total: shown_old};
            n_res    = 2'd1;
          end else begin
            res_d[0] = '{kind: KIND_DATA, data: held_q, total: shown_old};
            n_res    = 2'd1;
            ord      = 1'b1;
          end
        end
        default: begin
          esc_d = ESC_IDLE;
          ord   = 1'b1;
        end
      endcase

      // ordinary byte handling after any escape fallout
      if (ord) begin
        if (c == ChAmp) begin
          tally_d      = tally_inc;
          res_d[n_res] = '{kind: KIND_ELEM, data: 8'd0, total: shown_inc};
          n_res        = n_res + 2'd1;
        end else if (c == ChPct) begin
          esc_d = ESC_PCT;
        end else begin
          res_d[n_res] = '{kind: KIND_DATA, data: c, total: shown_old};
          n_res        = n_res + 2'd1;
        end
      end
    end

    // end of string returns to the reset state
    if (fin) begin
      expect_first_d = 1'b1;
      bad_start_d    = 1'b0;
      esc_d          = ESC_IDLE;
      held_d         = 8'd0;
      tally_d        = '0;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (s_acc) begin
      cnt_d = n_res;
      idx_d = 2'd0;
    end else if (last_take) begin
      cnt_d = 2'd0;
      idx_d = 2'd0;
    end else if (m_take) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_first_q <= 1'b1;
      bad_start_q    <= 1'b0;
      esc_q          <= ESC_IDLE;
      held_q         <= 8'd0;
      tally_q        <= '0;
      cnt_q          <= 2'd0;
      idx_q          <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
      if (s_acc) begin
        expect_first_q <= expect_first_d;
        bad_start_q    <= bad_start_d;
        esc_q          <= esc_d;
        held_q         <= held_d;
        tally_q        <= tally_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      for (int i = 0; i < int'(MaxRes); i++) begin
        buf_q[i] <= res_d[i];
      end
    end
  end

  res_t cur;
  assign cur = buf_q[idx_q];

  assign m_axis_tdata = {cur.total, cur.data};
  assign m_axis_tuser = cur.kind;
  assign m_axis_tlast = (idx_q == cnt_q - 2'd1);

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd0) |-> (idx_q < cnt_q))
    else $error("result index beyond buffer fill");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> s_axis_tready)
    else $error("input stalled with empty result buffer");

  a_fin_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && fin) |=> (expect_first_q && tally_q == '0))
    else $error("string end did not return to start state");

  a_bad_no_escape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bad_start_q |-> (esc_q == ESC_IDLE))
    else $error("escape pending on a bad string");

  a_end_kind_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_DONE || m_axis_tuser == KIND_BAD))
      |-> m_axis_tlast)
    else $error("string end result not last of its run");
`endif

endmodule
